// ===== rtl/iyht_pkg.sv =====
// Shared types and constants for the IMU yaw heading tracker.
// Holds the register map, the configuration struct and the transaction payload structs.
// No dependencies.
package iyht_pkg;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_STALE_LIMIT = 2'd0,
      REG_MAX_STEP    = 2'd1,
      REG_YAW_NEGATE  = 2'd2
   } reg_index_type;

   localparam logic [15:0] STALE_LIMIT_RESET = 16'd100;
   localparam logic [15:0] MAX_STEP_RESET    = 16'd2048;
   localparam logic        YAW_NEGATE_RESET  = 1'b0;
   localparam logic [15:0] COUNT_MAX         = 16'hFFFF;

   typedef struct packed {
      logic [15:0] stale_limit_ms;
      logic [15:0] max_step;
      logic        yaw_negate;
   } cfg_type;

   typedef struct packed {
      logic               func;
      logic signed [15:0] yaw_raw;
      logic [31:0]        frame_count;
      logic [31:0]        sample_time;
      logic [31:0]        now_time;
      logic signed [15:0] encoder_heading;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic signed [15:0] heading;
      logic               tracking;
      logic               fresh;
      logic               step_dropped;
      logic [15:0]        rejected_total;
      logic [15:0]        recovery_total;
   } rsp_type;

endpackage

// ===== rtl/iyht_csr.sv =====
// Configuration registers of the IMU yaw heading tracker, behind an APB-style port.
// Depends on iyht_pkg.
module iyht_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [iyht_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [iyht_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [iyht_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output iyht_pkg::cfg_type                  cfg
);
   import iyht_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign pready   = 1'b1;
   assign index    = reg_index_type'(paddr[3:2]);
   assign write_en = psel && penable && pwrite && pready;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_STALE_LIMIT: cfg_in.stale_limit_ms = pwdata[15:0];
            REG_MAX_STEP:    cfg_in.max_step       = pwdata[15:0];
            REG_YAW_NEGATE:  cfg_in.yaw_negate     = pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_STALE_LIMIT: prdata = {16'd0, cfg_ff.stale_limit_ms};
         REG_MAX_STEP:    prdata = {16'd0, cfg_ff.max_step};
         REG_YAW_NEGATE:  prdata = {31'd0, cfg_ff.yaw_negate};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stale_limit_ms <= STALE_LIMIT_RESET;
         cfg_ff.max_step       <= MAX_STEP_RESET;
         cfg_ff.yaw_negate     <= YAW_NEGATE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/iyht_core.sv =====
// Tracking state and single-pass update logic of the IMU yaw heading tracker.
// Depends on iyht_pkg; the state advances once per transaction taken from the input register.
module iyht_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  iyht_pkg::cfg_type  cfg,
   input  iyht_pkg::req_type  req,
   output iyht_pkg::rsp_type  rsp
);
   import iyht_pkg::*;

   logic        track_valid_ff, track_valid_in;
   logic [15:0] ref_yaw_ff, ref_yaw_in;
   logic [15:0] prev_yaw_ff, prev_yaw_in;
   logic [31:0] prev_frames_ff, prev_frames_in;
   logic [31:0] prev_sample_time_ff, prev_sample_time_in;
   logic [15:0] ref_heading_ff, ref_heading_in;
   logic [15:0] cur_heading_ff, cur_heading_in;
   logic [15:0] reject_count_ff, reject_count_in;
   logic [15:0] recover_count_ff, recover_count_in;

   logic [31:0] age_sample;
   logic [31:0] age_prev;
   logic        sample_stale;
   logic        gap;
   logic        good;
   logic        new_frame;
   logic        latch;
   logic        update;
   logic [15:0] step;
   logic [16:0] step_mag;
   logic        too_far;
   logic        reject;
   logic [15:0] offset;
   logic [15:0] offset_signed;

   assign age_sample    = req.now_time - req.sample_time;
   assign age_prev      = req.now_time - prev_sample_time_ff;
   assign sample_stale  = age_sample > {16'd0, cfg.stale_limit_ms};
   assign gap           = age_prev > {16'd0, cfg.stale_limit_ms};
   assign good          = (req.frame_count != 32'd0) && !sample_stale;
   assign new_frame     = req.frame_count != prev_frames_ff;
   assign latch         = good && (req.func || (!track_valid_ff && new_frame));
   assign update        = good && !req.func && track_valid_ff && new_frame;
   assign step          = req.yaw_raw - prev_yaw_ff;
   assign step_mag      = step[15] ? (17'd0 - {1'b1, step}) : {1'b0, step};
   assign too_far       = step_mag > {1'b0, cfg.max_step};
   assign reject        = update && !gap && too_far;
   assign offset        = req.yaw_raw - ref_yaw_ff;
   assign offset_signed = cfg.yaw_negate ? (16'd0 - offset) : offset;

   always_comb begin
      track_valid_in      = track_valid_ff;
      ref_yaw_in          = ref_yaw_ff;
      prev_yaw_in         = prev_yaw_ff;
      prev_frames_in      = prev_frames_ff;
      prev_sample_time_in = prev_sample_time_ff;
      ref_heading_in      = ref_heading_ff;
      cur_heading_in      = cur_heading_ff;
      reject_count_in     = reject_count_ff;
      recover_count_in    = recover_count_ff;
      if (latch) begin
         track_valid_in      = 1'b1;
         ref_yaw_in          = req.yaw_raw;
         prev_yaw_in         = req.yaw_raw;
         prev_frames_in      = req.frame_count;
         prev_sample_time_in = req.sample_time;
         ref_heading_in      = req.encoder_heading;
         cur_heading_in      = req.encoder_heading;
         reject_count_in     = '0;
         recover_count_in    = '0;
      end else if (update) begin
         prev_yaw_in         = req.yaw_raw;
         prev_frames_in      = req.frame_count;
         prev_sample_time_in = req.sample_time;
         if (reject) begin
            if (reject_count_ff != COUNT_MAX) begin
               reject_count_in = reject_count_ff + 16'd1;
            end
         end else begin
            cur_heading_in = ref_heading_ff + offset_signed;
            if (gap && (recover_count_ff != COUNT_MAX)) begin
               recover_count_in = recover_count_ff + 16'd1;
            end
         end
      end
   end

   always_comb begin
      rsp.accepted       = latch || update;
      rsp.heading        = cur_heading_in;
      rsp.tracking       = track_valid_in;
      rsp.fresh          = track_valid_in && ((latch || update) ? !sample_stale : !gap);
      rsp.step_dropped   = reject;
      rsp.rejected_total = reject_count_in;
      rsp.recovery_total = recover_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_valid_ff      <= 1'b0;
         ref_yaw_ff          <= '0;
         prev_yaw_ff         <= '0;
         prev_frames_ff      <= '0;
         prev_sample_time_ff <= '0;
         ref_heading_ff      <= '0;
         cur_heading_ff      <= '0;
         reject_count_ff     <= '0;
         recover_count_ff    <= '0;
      end else if (fire) begin
         track_valid_ff      <= track_valid_in;
         ref_yaw_ff          <= ref_yaw_in;
         prev_yaw_ff         <= prev_yaw_in;
         prev_frames_ff      <= prev_frames_in;
         prev_sample_time_ff <= prev_sample_time_in;
         ref_heading_ff      <= ref_heading_in;
         cur_heading_ff      <= cur_heading_in;
         reject_count_ff     <= reject_count_in;
         recover_count_ff    <= recover_count_in;
      end
   end

   a_accept_tracks: assert property (@(posedge clock) disable iff (reset)
      fire && rsp.accepted |=> track_valid_ff)
      else $error("Accepted transaction did not leave a valid track.");

   a_drop_counted: assert property (@(posedge clock) disable iff (reset)
      fire && rsp.step_dropped |=> reject_count_ff != 16'd0)
      else $error("Rejected step was not counted.");

   a_drop_holds_heading: assert property (@(posedge clock) disable iff (reset)
      fire && rsp.step_dropped |=> $stable(cur_heading_ff))
      else $error("Rejected step changed the heading.");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(cur_heading_ff) && $stable(prev_frames_ff)
                && $stable(track_valid_ff))
      else $error("Tracking state changed without a transaction.");

   a_fresh_needs_track: assert property (@(posedge clock) disable iff (reset)
      fire && rsp.fresh |=> track_valid_ff)
      else $error("Fresh result reported without a track.");

endmodule

// ===== rtl/imu_yaw_heading_tracker_unit.sv =====
// Top level of the IMU yaw heading tracker: input register, result register and handshakes.
// Depends on iyht_pkg, iyht_csr and iyht_core.
//
//   Channel   Direction  Handshake             Contents
//   req_*     in         req_valid/req_ready   one IMU yaw frame per transaction
//   rsp_*     out        rsp_valid/rsp_ready   one tracking result per transaction
//   csr       in/out     psel/penable/pready   stale limit, step limit, yaw sign
//
// One transaction per cycle is sustained while rsp_ready stays high; a frame passes through
// the input register and then the result register before its result turns valid.
// The single-pass update of the tracking state from the input register sets that rate.
// When rsp_ready is low while a result is valid, the result register holds, the input
// register holds its frame, and req_ready stays high only while the input register is empty.
// Reset clears the handshake state, the tracking state and the configuration registers to their defaults.
module imu_yaw_heading_tracker_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_func,
   input  logic signed [15:0]              req_yaw_raw,
   input  logic [31:0]                     req_frame_count,
   input  logic [31:0]                     req_sample_time,
   input  logic [31:0]                     req_now_time,
   input  logic signed [15:0]              req_encoder_heading,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_accepted,
   output logic signed [15:0]              rsp_heading,
   output logic                            rsp_tracking,
   output logic                            rsp_fresh,
   output logic                            rsp_step_dropped,
   output logic [15:0]                     rsp_rejected_total,
   output logic [15:0]                     rsp_recovery_total,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [iyht_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [iyht_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [iyht_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import iyht_pkg::*;

   cfg_type cfg;
   req_type req_ff;
   logic    req_valid_ff;
   rsp_type rsp_ff;
   rsp_type core_rsp;
   logic    rsp_valid_ff;
   logic    advance;
   logic    fire;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid_ff && advance;
   assign req_ready = !req_valid_ff || advance;

   iyht_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   iyht_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .cfg   (cfg),
      .req   (req_ff),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff.func            <= req_func;
         req_ff.yaw_raw         <= req_yaw_raw;
         req_ff.frame_count     <= req_frame_count;
         req_ff.sample_time     <= req_sample_time;
         req_ff.now_time        <= req_now_time;
         req_ff.encoder_heading <= req_encoder_heading;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_ff.accepted;
   assign rsp_heading        = rsp_ff.heading;
   assign rsp_tracking       = rsp_ff.tracking;
   assign rsp_fresh          = rsp_ff.fresh;
   assign rsp_step_dropped   = rsp_ff.step_dropped;
   assign rsp_rejected_total = rsp_ff.rejected_total;
   assign rsp_recovery_total = rsp_ff.recovery_total;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for imu_yaw_heading_tracker_unit: directed frames, random frame
// streams under several register settings, and alternating gap recoveries and rejected steps.
// Depends on iyht_pkg and the RTL of the block; it needs no other file.
module testbench;
   import iyht_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned SETTLE_TICKS = 4;
   localparam int unsigned HOLD_TICKS   = 64;
   localparam int unsigned PHASE_FRAMES = 300;
   localparam int unsigned FILL_PAIRS   = 10;

   // Tracks the heading from every frame the block takes and compares each result.
   class yaw_track_model;
      logic [15:0] stale_limit;
      logic [15:0] max_step;
      logic        negate;
      logic        track_valid;
      logic [15:0] ref_yaw;
      logic [15:0] prev_yaw;
      logic [31:0] prev_frames;
      logic [31:0] prev_sample_time;
      logic [15:0] ref_heading;
      logic [15:0] cur_heading;
      logic [15:0] reject_count;
      logic [15:0] recover_count;
      rsp_type     due_results[$];
      int unsigned failures;

      function new();
         stale_limit      = STALE_LIMIT_RESET;
         max_step         = MAX_STEP_RESET;
         negate           = YAW_NEGATE_RESET;
         track_valid      = 1'b0;
         ref_yaw          = '0;
         prev_yaw         = '0;
         prev_frames      = '0;
         prev_sample_time = '0;
         ref_heading      = '0;
         cur_heading      = '0;
         reject_count     = '0;
         recover_count    = '0;
         failures         = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_STALE_LIMIT: stale_limit = value[15:0];
            REG_MAX_STEP:    max_step    = value[15:0];
            REG_YAW_NEGATE:  negate      = value[0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(reg_index_type idx);
         case (idx)
            REG_STALE_LIMIT: return {16'd0, stale_limit};
            REG_MAX_STEP:    return {16'd0, max_step};
            REG_YAW_NEGATE:  return {31'd0, negate};
            default:         return '0;
         endcase
      endfunction

      function bit aged(logic [31:0] now_ms, logic [31:0] then_ms);
         logic [31:0] span;
         span = now_ms - then_ms;
         return span > {16'd0, stale_limit};
      endfunction

      function logic [15:0] bump(logic [15:0] count);
         return (count == COUNT_MAX) ? count : count + 16'd1;
      endfunction

      function void latch(req_type f);
         track_valid      = 1'b1;
         ref_yaw          = f.yaw_raw;
         prev_yaw         = f.yaw_raw;
         prev_frames      = f.frame_count;
         prev_sample_time = f.sample_time;
         reject_count     = '0;
         recover_count    = '0;
         ref_heading      = f.encoder_heading;
         cur_heading      = f.encoder_heading;
      endfunction

      function void frame_taken(req_type f);
         logic        good;
         logic        gap;
         logic [15:0] step;
         logic [15:0] mag;
         logic [15:0] off;
         rsp_type     r;
         r.accepted     = 1'b0;
         r.step_dropped = 1'b0;
         good = (f.frame_count != 32'd0) && !aged(f.now_time, f.sample_time);
         if (f.func) begin
            if (good) begin
               latch(f);
               r.accepted = 1'b1;
            end
         end else if (good && f.frame_count != prev_frames) begin
            r.accepted = 1'b1;
            if (!track_valid) begin
               latch(f);
            end else begin
               gap  = aged(f.now_time, prev_sample_time);
               step = f.yaw_raw - prev_yaw;
               mag  = step[15] ? -step : step;
               prev_yaw         = f.yaw_raw;
               prev_frames      = f.frame_count;
               prev_sample_time = f.sample_time;
               if (!gap && mag > max_step) begin
                  reject_count   = bump(reject_count);
                  r.step_dropped = 1'b1;
               end else begin
                  if (gap) recover_count = bump(recover_count);
                  off = f.yaw_raw - ref_yaw;
                  if (negate) off = -off;
                  cur_heading = ref_heading + off;
               end
            end
         end
         r.heading        = cur_heading;
         r.tracking       = track_valid;
         r.fresh          = track_valid && !aged(f.now_time, prev_sample_time);
         r.rejected_total = reject_count;
         r.recovery_total = recover_count;
         due_results.push_back(r);
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
            failures++;
         end
      endfunction

      function void result_seen(rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            $error("result transaction arrived with no frame outstanding");
            failures++;
            return;
         end
         want = due_results.pop_front();
         compare("accepted", 32'(want.accepted), 32'(got.accepted));
         compare("heading", 32'(want.heading), 32'(got.heading));
         compare("tracking", 32'(want.tracking), 32'(got.tracking));
         compare("fresh", 32'(want.fresh), 32'(got.fresh));
         compare("step_dropped", 32'(want.step_dropped), 32'(got.step_dropped));
         compare("rejected_total", 32'(want.rejected_total), 32'(got.rejected_total));
         compare("recovery_total", 32'(want.recovery_total), 32'(got.recovery_total));
      endfunction

      function int unsigned pending();
         return due_results.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_func;
   logic signed [15:0]    req_yaw_raw;
   logic [31:0]           req_frame_count;
   logic [31:0]           req_sample_time;
   logic [31:0]           req_now_time;
   logic signed [15:0]    req_encoder_heading;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_accepted;
   logic signed [15:0]    rsp_heading;
   logic                  rsp_tracking;
   logic                  rsp_fresh;
   logic                  rsp_step_dropped;
   logic [15:0]           rsp_rejected_total;
   logic [15:0]           rsp_recovery_total;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   yaw_track_model track = new();
   bit             idle_off;
   bit             hold_results;
   int unsigned    cycle_count;
   req_type        taken_frame;
   rsp_type        seen_result;
   logic [31:0]    ms_now;
   logic [31:0]    frame_seq;
   logic [31:0]    last_frames;
   logic [15:0]    yaw_last;

   imu_yaw_heading_tracker_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_yaw_raw         (req_yaw_raw),
      .req_frame_count     (req_frame_count),
      .req_sample_time     (req_sample_time),
      .req_now_time        (req_now_time),
      .req_encoder_heading (req_encoder_heading),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_accepted        (rsp_accepted),
      .rsp_heading         (rsp_heading),
      .rsp_tracking        (rsp_tracking),
      .rsp_fresh           (rsp_fresh),
      .rsp_step_dropped    (rsp_step_dropped),
      .rsp_rejected_total  (rsp_rejected_total),
      .rsp_recovery_total  (rsp_recovery_total),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            taken_frame = {req_func, req_yaw_raw, req_frame_count, req_sample_time,
                           req_now_time, req_encoder_heading};
            track.frame_taken(taken_frame);
         end
         if (rsp_valid && rsp_ready) begin
            seen_result = {rsp_accepted, rsp_heading, rsp_tracking, rsp_fresh,
                           rsp_step_dropped, rsp_rejected_total, rsp_recovery_total};
            track.result_seen(seen_result);
         end
      end
   end

   function automatic int unsigned idle_draw();
      return idle_off ? 0 : $urandom_range(0, 4);
   endfunction

   function automatic req_type frame(logic fn, logic [15:0] yaw, logic [31:0] frames,
                                     logic [31:0] stime, logic [31:0] now_ms,
                                     logic [15:0] enc);
      req_type f;
      f.func            = fn;
      f.yaw_raw         = yaw;
      f.frame_count     = frames;
      f.sample_time     = stime;
      f.now_time        = now_ms;
      f.encoder_heading = enc;
      return f;
   endfunction

   // Result side: random stalls per transaction, plus one long hold when asked.
   initial begin : result_side
      int unsigned idle;
      rsp_ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (hold_results) begin
            hold_results = 1'b0;
            rsp_ready = 1'b0;
            repeat (HOLD_TICKS) @(negedge clock);
         end
         idle = idle_draw();
         if (idle != 0) begin
            rsp_ready = 1'b0;
            repeat (idle) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // All driving tasks start and end just after a falling edge.
   task automatic send_frame(req_type f);
      int unsigned idle;
      idle = idle_draw();
      if (idle != 0) begin
         req_valid = 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_func            = f.func;
      req_yaw_raw         = f.yaw_raw;
      req_frame_count     = f.frame_count;
      req_sample_time     = f.sample_time;
      req_now_time        = f.now_time;
      req_encoder_heading = f.encoder_heading;
      req_valid           = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain();
      while (track.pending() != 0) @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      psel    = 1'b1;
      pwrite  = 1'b1;
      penable = 1'b0;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      track.set_reg(idx, value);
      @(negedge clock);
      pwrite  = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      track.compare("prdata", track.reg_value(idx), prdata);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic configure(logic [15:0] stale, logic [15:0] step, logic neg);
      drain();
      write_reg(REG_STALE_LIMIT, {16'd0, stale});
      write_reg(REG_MAX_STEP, {16'd0, step});
      write_reg(REG_YAW_NEGATE, {31'd0, neg});
   endtask

   // Mostly well-formed frames: advancing time, fresh samples, new frame counts and
   // steps near the limit; some empty, repeated, stale, future-dated or wild frames.
   task automatic send_random_frame();
      logic [31:0] lim;
      logic [31:0] age;
      logic [31:0] frames;
      logic [15:0] yaw;
      int unsigned delta;
      lim = {16'd0, track.stale_limit};
      if ($urandom_range(0, 15) == 0) ms_now += lim + $urandom_range(1, 300);
      else ms_now += $urandom_range(0, lim / 3 + 1);
      case ($urandom_range(0, 19))
         0:       age = lim + 1 + $urandom_range(0, 500);
         1:       age = -$urandom_range(1, 500);
         default: age = $urandom_range(0, lim);
      endcase
      case ($urandom_range(0, 19))
         0: frames = '0;
         1: frames = last_frames;
         2: frames = $urandom;
         default: begin
            frame_seq++;
            frames = frame_seq;
         end
      endcase
      last_frames = frames;
      if ($urandom_range(0, 9) == 0) begin
         yaw = 16'($urandom);
      end else begin
         delta = $urandom_range(0, track.max_step + track.max_step / 8);
         yaw = $urandom_range(0, 1) ? yaw_last + delta[15:0] : yaw_last - delta[15:0];
      end
      yaw_last = yaw;
      send_frame(frame($urandom_range(0, 19) == 0, yaw, frames, ms_now - age, ms_now,
                       16'($urandom)));
   endtask

   initial begin : stimulus
      logic [31:0] t0;
      logic [31:0] t;
      logic [31:0] fs;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_func            = 1'b0;
      req_yaw_raw         = '0;
      req_frame_count     = '0;
      req_sample_time     = '0;
      req_now_time        = '0;
      req_encoder_heading = '0;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      idle_off            = 1'b0;
      hold_results        = 1'b0;
      cycle_count         = 0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Directed frames under the reset settings.
      t0 = 32'h0000_1000;
      send_frame(frame(1'b0, 16'h1234, 32'd0, t0, t0, 16'h0));
      send_frame(frame(1'b0, 16'h0, 32'd1, t0 - 101, t0, 16'h0));
      send_frame(frame(1'b0, 16'h0, 32'd1, t0 + 1, t0, 16'h0));
      send_frame(frame(1'b1, 16'h0, 32'd1, t0 - 101, t0, 16'h0));
      send_frame(frame(1'b1, 16'h0, 32'd0, t0, t0, 16'h0));
      send_frame(frame(1'b0, 16'h8000, 32'd1, t0 - 100, t0, 16'h7FFF));
      send_frame(frame(1'b0, 16'h8800, 32'd2, t0 + 10, t0 + 10, 16'h0));
      send_frame(frame(1'b0, 16'h9001, 32'd3, t0 + 20, t0 + 20, 16'h0));
      send_frame(frame(1'b0, 16'h0, 32'd3, t0 + 20, t0 + 20, 16'h0));
      send_frame(frame(1'b0, 16'h1001, 32'd4, t0 + 30, t0 + 30, 16'h0));
      send_frame(frame(1'b0, 16'h7FFF, 32'd5, t0 + 200, t0 + 200, 16'h0));
      send_frame(frame(1'b0, 16'h0, 32'd0, t0 + 400, t0 + 400, 16'h0));
      send_frame(frame(1'b1, 16'h7FFF, 32'd5, t0 + 400, t0 + 400, 16'h8000));
      send_frame(frame(1'b0, 16'h8000, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
                       16'h7FFF));
      send_frame(frame(1'b0, 16'h8001, 32'h8000_0000, 32'hFFFF_FFFE, 32'h0000_0005,
                       16'h0));
      send_frame(frame(1'b1, 16'h5555, 32'h0000_0001, 32'h0, 32'h0, 16'hAAAA));

      // Half-turn steps at the widest step limit, with the yaw sign inverted.
      configure(16'd100, 16'd32768, 1'b1);
      send_frame(frame(1'b1, 16'h0, 32'd7, t0, t0, 16'h0));
      send_frame(frame(1'b0, 16'h8000, 32'd8, t0, t0, 16'h0));
      send_frame(frame(1'b0, 16'h7000, 32'd9, t0, t0, 16'h1234));

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: configure(STALE_LIMIT_RESET, MAX_STEP_RESET, YAW_NEGATE_RESET);
            1: configure(16'd0, 16'd0, 1'b1);
            2: configure(16'hFFFF, 16'd32768, 1'b0);
            3: configure(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 32768)),
                         1'($urandom_range(0, 1)));
            4: configure(16'($urandom), 16'($urandom_range(0, 32768)),
                         1'($urandom_range(0, 1)));
            default: configure(16'd20, 16'd300, 1'b1);
         endcase
         ms_now      = $urandom;
         frame_seq   = $urandom;
         last_frames = frame_seq;
         yaw_last    = 16'($urandom);
         for (int n = 0; n < PHASE_FRAMES; n++) begin
            if (n % 50 == 0) idle_off = ($urandom_range(0, 3) == 0);
            if (n == 60) hold_results = 1'b1;
            if (n == 150) while (track.pending() != 0) @(negedge clock);
            send_random_frame();
         end
      end

      // Alternate stale-gap recoveries and rejected steps, back to back.
      configure(16'd0, 16'd0, 1'b0);
      idle_off = 1'b1;
      t  = $urandom;
      fs = $urandom_range(1, 1000);
      send_frame(frame(1'b1, 16'h0, fs, t, t, 16'h4000));
      for (int k = 0; k < FILL_PAIRS; k++) begin
         t  = t + 1;
         fs = fs + 2;
         send_frame(frame(1'b0, 16'h0100, fs - 1, t, t, 16'h0));
         send_frame(frame(1'b0, 16'h0000, fs, t, t, 16'h0));
      end
      send_frame(frame(1'b1, 16'h0, fs, t, t, 16'h0));
      idle_off = 1'b0;

      drain();
      repeat (8) @(negedge clock);
      if (track.pending() != 0) begin
         $error("%0d expected results never arrived", track.pending());
         track.failures++;
      end
      if (track.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== imu_yaw_heading_tracker_unit.f =====
rtl/iyht_pkg.sv
rtl/iyht_csr.sv
rtl/iyht_core.sv
rtl/imu_yaw_heading_tracker_unit.sv
dv/testbench.sv
